[rtl/core/pva_pkg.sv]
// ----------------------------------------------------------------------------
// pva_pkg
// Shared field widths, event and status codes, and controller command type
// for the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned NOTE_W   = 7;
   localparam int unsigned VEL_W    = 7;
   localparam int unsigned REQPOS_W = 4;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned NEWPOS_W = 3;
   localparam int unsigned MASK_W   = 8;
   localparam int unsigned ACTIVE_W = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_NOTE_ON  = 2'd0,
      FUNC_NOTE_OFF = 2'd1,
      FUNC_ALL_OFF  = 2'd2,
      FUNC_DELETE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_STARTED   = 3'd0,
      STATUS_DUPLICATE = 3'd1,
      STATUS_RELEASED  = 3'd2,
      STATUS_DELETED   = 3'd3,
      STATUS_RANGE     = 3'd4
   } status_type;

   typedef struct packed {
      logic load;
      logic execute;
   } pva_cmd_type;

endpackage

[rtl/core/pva_req_if.sv]
// ----------------------------------------------------------------------------
// pva_req_if
// Event channel: valid/ready handshake with the voice event payload.
// ----------------------------------------------------------------------------
interface pva_req_if;
   import pva_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [NOTE_W-1:0]   note;
   logic [VEL_W-1:0]    velocity;
   logic [REQPOS_W-1:0] position;

   modport source (output valid, output func, output note, output velocity,
                   output position, input ready);
   modport sink   (input valid, input func, input note, input velocity,
                   input position, output ready);
endinterface

[rtl/core/pva_rsp_if.sv]
// ----------------------------------------------------------------------------
// pva_rsp_if
// Result channel: valid/ready handshake with the allocation result payload.
// ----------------------------------------------------------------------------
interface pva_rsp_if;
   import pva_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NEWPOS_W-1:0] new_position;
   logic                stole_oldest;
   logic [NOTE_W-1:0]   stolen_note;
   logic [MASK_W-1:0]   released_mask;
   logic [ACTIVE_W-1:0] active_count;

   modport source (output valid, output status, output new_position,
                   output stole_oldest, output stolen_note, output released_mask,
                   output active_count, input ready);
   modport sink   (input valid, input status, input new_position,
                   input stole_oldest, input stolen_note, input released_mask,
                   input active_count, output ready);
endinterface

[rtl/core/pva_ctrl.sv]
// ----------------------------------------------------------------------------
// pva_ctrl
// Two-state sequencer: captures one event, then executes it into the
// result register once that register is free.
// ----------------------------------------------------------------------------
module pva_ctrl
   import pva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pva_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.load    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (cmd.execute) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second event taken while one is in flight");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid)
      else $error("executed event produced no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

[rtl/core/pva_datapath.sv]
// ----------------------------------------------------------------------------
// pva_datapath
// Age-ordered voice slots, event operand register and result register.
// Matching, append, steal and gap closing are done across all slots at once.
// ----------------------------------------------------------------------------
module pva_datapath
   import pva_pkg::*;
#(
   parameter int unsigned MAX_VOICES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  pva_cmd_type         cmd,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [NOTE_W-1:0]   req_note,
   input  logic [VEL_W-1:0]    req_velocity,
   input  logic [REQPOS_W-1:0] req_position,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [NEWPOS_W-1:0] rsp_new_position,
   output logic                rsp_stole_oldest,
   output logic [NOTE_W-1:0]   rsp_stolen_note,
   output logic [MASK_W-1:0]   rsp_released_mask,
   output logic [ACTIVE_W-1:0] rsp_active_count
);

   localparam int unsigned CNT_W = $clog2(MAX_VOICES + 1);
   localparam int unsigned CMP_W = (CNT_W > REQPOS_W) ? CNT_W : REQPOS_W;

   func_type            op_func_ff;
   logic [NOTE_W-1:0]   op_note_ff;
   logic [VEL_W-1:0]    op_vel_ff;
   logic [REQPOS_W-1:0] op_pos_ff;

   logic [NOTE_W-1:0]   note_ff [MAX_VOICES];
   logic [NOTE_W-1:0]   note_in [MAX_VOICES];
   logic [VEL_W-1:0]    vel_ff  [MAX_VOICES];
   logic [VEL_W-1:0]    vel_in  [MAX_VOICES];
   logic [MAX_VOICES-1:0] rel_ff, rel_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   logic [MAX_VOICES-1:0] active, match, mask_wide;
   logic                full;
   status_type          status_in;
   logic [CNT_W-1:0]    newpos_wide;
   logic                stole_in;
   logic [NOTE_W-1:0]   stolen_in;
   logic [MASK_W-1:0]   mask_in;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if ((func_type'(req_func) == FUNC_NOTE_ON) && (req_velocity == '0)) begin
            op_func_ff <= FUNC_NOTE_OFF;
         end else begin
            op_func_ff <= func_type'(req_func);
         end
         op_note_ff <= req_note;
         op_vel_ff  <= req_velocity;
         op_pos_ff  <= req_position;
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_VOICES; k++) begin
         active[k] = CNT_W'(k) < count_ff;
         match[k]  = active[k] && (note_ff[k] == op_note_ff) && !rel_ff[k];
      end
      full = (count_ff == CNT_W'(MAX_VOICES));
   end

   always_comb begin
      note_in     = note_ff;
      vel_in      = vel_ff;
      rel_in      = rel_ff;
      count_in    = count_ff;
      status_in   = STATUS_RELEASED;
      newpos_wide = '0;
      stole_in    = 1'b0;
      stolen_in   = '0;
      mask_wide   = '0;
      unique case (op_func_ff)
         FUNC_NOTE_ON: begin
            if (|match) begin
               status_in = STATUS_DUPLICATE;
            end else if (full) begin
               status_in = STATUS_STARTED;
               stole_in  = 1'b1;
               stolen_in = note_ff[0];
               for (int k = 0; k < MAX_VOICES - 1; k++) begin
                  note_in[k] = note_ff[k+1];
                  vel_in[k]  = vel_ff[k+1];
                  rel_in[k]  = rel_ff[k+1];
               end
               note_in[MAX_VOICES-1] = op_note_ff;
               vel_in[MAX_VOICES-1]  = op_vel_ff;
               rel_in[MAX_VOICES-1]  = 1'b0;
               newpos_wide = CNT_W'(MAX_VOICES - 1);
            end else begin
               status_in = STATUS_STARTED;
               for (int k = 0; k < MAX_VOICES; k++) begin
                  if (CNT_W'(k) == count_ff) begin
                     note_in[k] = op_note_ff;
                     vel_in[k]  = op_vel_ff;
                     rel_in[k]  = 1'b0;
                  end
               end
               newpos_wide = count_ff;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         FUNC_NOTE_OFF: begin
            rel_in    = rel_ff | match;
            mask_wide = match;
         end
         FUNC_ALL_OFF: begin
            rel_in    = rel_ff | active;
            mask_wide = active & ~rel_ff;
         end
         FUNC_DELETE: begin
            if (CMP_W'(op_pos_ff) >= CMP_W'(count_ff)) begin
               status_in = STATUS_RANGE;
            end else begin
               status_in = STATUS_DELETED;
               for (int k = 0; k < MAX_VOICES - 1; k++) begin
                  if (CMP_W'(k) >= CMP_W'(op_pos_ff)) begin
                     note_in[k] = note_ff[k+1];
                     vel_in[k]  = vel_ff[k+1];
                     rel_in[k]  = rel_ff[k+1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: status_in = STATUS_RELEASED;
      endcase
   end

   // only the eight lowest (oldest) positions are reported
   for (genvar b = 0; b < MASK_W; b++) begin : g_mask
      if (b < MAX_VOICES) begin : g_used
         assign mask_in[b] = mask_wide[b];
      end else begin : g_pad
         assign mask_in[b] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         rel_ff   <= rel_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         note_ff           <= note_in;
         vel_ff            <= vel_in;
         rsp_status        <= status_in;
         rsp_new_position  <= NEWPOS_W'(newpos_wide);
         rsp_stole_oldest  <= stole_in;
         rsp_stolen_note   <= stolen_in;
         rsp_released_mask <= mask_in;
         rsp_active_count  <= ACTIVE_W'(count_in);
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VOICES))
      else $error("voice count above capacity");

   a_steal_only_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && stole_in) |-> full)
      else $error("voice stolen from a list that is not full");
`endif

endmodule

[rtl/core/poly_voice_allocator_unit.sv]
// ----------------------------------------------------------------------------
// poly_voice_allocator_unit
// Polyphonic voice allocator with oldest-voice stealing.
//
// Events enter on the req channel (note on, note off, all notes off, delete
// at position); every event yields exactly one transfer on the rsp channel.
// Voices are kept in age order in flip-flops, position 0 the oldest.
// An event is captured into the operand register at its req transfer and
// executed into the rsp register, raising rsp valid, once that register is
// free; the capture/execute sequencer takes no new event until the
// previous one has been executed.
// A new event is taken while the previous result still waits in the rsp
// register; if the receiver stalls, execution of that event holds until the
// register is free, and req ready stays low meanwhile.
// Synchronous reset empties the voice list and clears rsp valid;
// no clearing pass is needed, the block accepts events the cycle after.
// ----------------------------------------------------------------------------
module poly_voice_allocator_unit
   import pva_pkg::*;
#(
   parameter int unsigned MAX_VOICES = 8
) (
   input logic      clock,
   input logic      reset,
   pva_req_if.sink  req_ch,
   pva_rsp_if.source rsp_ch
);

   pva_cmd_type cmd;

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   pva_datapath #(
      .MAX_VOICES (MAX_VOICES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_ch.func),
      .req_note          (req_ch.note),
      .req_velocity      (req_ch.velocity),
      .req_position      (req_ch.position),
      .rsp_status        (rsp_ch.status),
      .rsp_new_position  (rsp_ch.new_position),
      .rsp_stole_oldest  (rsp_ch.stole_oldest),
      .rsp_stolen_note   (rsp_ch.stolen_note),
      .rsp_released_mask (rsp_ch.released_mask),
      .rsp_active_count  (rsp_ch.active_count)
   );

endmodule
